FILE: rtl/pcrc_pkg.sv
// Shared types, constants and the byte-wise CRC-32 update for the page CRC checker.
// No dependencies.
package pcrc_pkg;

    localparam int MAX_PAGES = 8192;
    localparam int PAGE_W    = 13;
    localparam int CNT_W     = 14;
    localparam int CRC_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int STAT_W    = 2;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

    // status codes
    localparam logic [STAT_W-1:0] ST_MATCH    = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd1;
    localparam logic [STAT_W-1:0] ST_STORED   = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

    // configuration register indexes
    localparam logic CFG_LEARN_MODE = 1'b0;
    localparam logic CFG_PAGE_COUNT = 1'b1;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // one finished page, handed from front to back
    typedef struct packed {
        logic [PAGE_W-1:0] idx;
        logic [CRC_W-1:0]  crc;
        logic              learn;
        logic              range_err;
    } pcrc_rec_t;

    // reflected CRC-32, one byte, bit-serial form unrolled to XOR logic
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/page_crc32_integrity_checker.sv
// Page CRC-32 checker: learns or checks a reflected CRC-32 per code page.
// One byte per cycle unless the queue is full; the CRC byte update is one XOR network.
// A page result passes the queue, the baseline RAM read into the stage-1 registers and
// the compare into the output register after its last byte is accepted.
// Reset (aresetn low, synchronous): CRC restarts at all ones, queue and output
// empty, learn_mode and page_count cleared; the baseline RAM is not cleared.
module page_crc32_integrity_checker import pcrc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] data_byte, [20:8] page_index, [23:21] zero
    input  logic        s_tlast,   // last_byte
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [12:0] result_page, [44:13] page_crc, [47:45] zero
    output logic [1:0]  m_tuser,   // status
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index, // 0 learn_mode, 1 page_count
    input  logic [13:0] cfg_data
);

    logic              learn_reg;
    logic [CNT_W-1:0]  page_count_reg;
    logic              push;
    pcrc_rec_t         push_rec;
    logic              pop;
    pcrc_rec_t         pop_rec;
    logic              q_full;
    logic              q_empty;
    logic [PAGE_W-1:0] result_page;
    logic [CRC_W-1:0]  page_crc;
    logic [STAT_W-1:0] status;

    // configuration regs: user must write only while no page in flight; not enforced
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learn_reg      <= 1'b0;
            page_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LEARN_MODE: learn_reg      <= cfg_data[0];
                CFG_PAGE_COUNT: page_count_reg <= cfg_data[CNT_W-1:0];
                default:        learn_reg      <= learn_reg;
            endcase
        end
    end

    // front: byte CRC and per-page classification
    pcrc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .data_byte  (s_tdata[BYTE_W-1:0]),
        .page_index (s_tdata[BYTE_W+PAGE_W-1:BYTE_W]),
        .last_byte  (s_tlast),
        .learn_mode (learn_reg),
        .page_count (page_count_reg),
        .q_full     (q_full),
        .push       (push),
        .push_rec   (push_rec)
    );

    // decoupling queue of finished pages
    pcrc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .full     (q_full),
        .empty    (q_empty)
    );

    // back: baseline store/compare and output register
    pcrc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_rec       (pop_rec),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .result_page (result_page),
        .page_crc    (page_crc),
        .status      (status)
    );

    assign m_tdata = {3'b000, page_crc, result_page};
    assign m_tuser = status;

endmodule

FILE: rtl/pcrc_front.sv
// Front end: accepts page bytes, runs the CRC and classifies each finished page.
// Depends on pcrc_pkg.
module pcrc_front import pcrc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [PAGE_W-1:0] page_index,
    input  logic              last_byte,
    input  logic              learn_mode,
    input  logic [CNT_W-1:0]  page_count,
    input  logic              q_full,
    output logic              push,
    output pcrc_rec_t         push_rec
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] crc_upd;
    logic             accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign crc_upd  = crc_byte(crc_reg, data_byte);

    always_comb begin
        crc_next = crc_reg;
        if (accept) begin
            crc_next = last_byte ? CRC_ONES : crc_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_ONES;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign push               = accept && last_byte;
    assign push_rec.idx       = page_index;
    assign push_rec.crc       = crc_upd ^ CRC_ONES;
    assign push_rec.learn     = learn_mode;
    assign push_rec.range_err = {1'b0, page_index} >= page_count;

endmodule

FILE: rtl/pcrc_queue.sv
// Short FIFO of finished page records between front and back.
// Depends on pcrc_pkg.
module pcrc_queue import pcrc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  pcrc_rec_t push_rec,
    input  logic      pop,
    output pcrc_rec_t pop_rec,
    output logic      full,
    output logic      empty
);

    pcrc_rec_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full    = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign pop_rec = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

FILE: rtl/pcrc_back.sv
// Back end: baseline store, compare and output register for page results.
// Depends on pcrc_pkg.
module pcrc_back import pcrc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  pcrc_rec_t         q_rec,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [PAGE_W-1:0] result_page,
    output logic [CRC_W-1:0]  page_crc,
    output logic [STAT_W-1:0] status
);

    logic [CRC_W-1:0]  baseline_mem [MAX_PAGES];
    logic [CRC_W-1:0]  rd_data_reg;
    pcrc_rec_t         s1_rec_reg;
    logic              s1_valid_reg, s1_valid_next;
    logic              m_valid_reg, m_valid_next;
    logic [PAGE_W-1:0] page_reg;
    logic [CRC_W-1:0]  crc_reg;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_calc;
    logic              out_free;
    logic              adv;

    assign out_free = !m_valid_reg || m_tready;
    assign adv      = s1_valid_reg && out_free;
    assign pop      = !q_empty && (!s1_valid_reg || out_free);

    always_comb begin
        if (s1_rec_reg.range_err) begin
            status_calc = ST_RANGE;
        end else if (s1_rec_reg.learn) begin
            status_calc = ST_STORED;
        end else if (rd_data_reg == s1_rec_reg.crc) begin
            status_calc = ST_MATCH;
        end else begin
            status_calc = ST_MISMATCH;
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (pop) begin
            s1_valid_next = 1'b1;
        end else if (adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // baseline store: write on in-range learn, registered read otherwise
    always_ff @(posedge aclk) begin
        if (pop) begin
            if (q_rec.learn && !q_rec.range_err) begin
                baseline_mem[q_rec.idx] <= q_rec.crc;
            end else begin
                rd_data_reg <= baseline_mem[q_rec.idx];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_rec_reg <= q_rec;
        end
        if (adv) begin
            page_reg   <= s1_rec_reg.idx;
            crc_reg    <= s1_rec_reg.crc;
            status_reg <= status_calc;
        end
    end

    assign m_tvalid    = m_valid_reg;
    assign result_page = page_reg;
    assign page_crc    = crc_reg;
    assign status      = status_reg;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for page_crc32_integrity_checker: directed table, then
// random learn/check phases, with a CRC-32 page predictor and result scoreboard.
// Depends on pcrc_pkg and the checker RTL only.
module testbench;
    import pcrc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 8;      // margin beyond the result latency
    localparam int POOL_N       = 24;     // pages replayed between learn and check
    localparam int BUF_MAX      = 64;     // longest page in bytes

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [CRC_W-1:0]  crc;
        logic [STAT_W-1:0] status;
    } page_result_t;

    // one directed step: a register write or one byte item
    typedef struct {
        bit                is_reg;
        logic              reg_sel;
        logic [CNT_W-1:0]  reg_val;
        logic [BYTE_W-1:0] data;
        logic [PAGE_W-1:0] page;
        bit                last;
        bit                known;    // expectation typed in below
        logic [CRC_W-1:0]  crc;
        logic [STAT_W-1:0] status;
    } stim_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;  // [7:0] data_byte, [20:8] page_index, [23:21] zero
    logic        s_tlast   = 1'b0; // last_byte
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;         // [12:0] result_page, [44:13] page_crc, [47:45] zero
    logic [1:0]  m_tuser;         // status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [13:0] cfg_data  = '0;

    page_crc32_integrity_checker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Page CRC predictor: table-driven reflected CRC-32 plus baseline store
    // ------------------------------------------------------------------
    logic [CRC_W-1:0] crc_table [0:255];
    logic [CRC_W-1:0] run_crc = CRC_ONES;
    bit               model_learn = 1'b0;
    logic [CNT_W-1:0] model_pages = '0;
    logic [CRC_W-1:0] baseline [0:MAX_PAGES-1];
    bit               learned  [0:MAX_PAGES-1];  // guards against reading unwritten entries
    page_result_t     pending_results [$];

    function automatic logic [CRC_W-1:0] crc_table_entry(input int unsigned n);
        logic [CRC_W-1:0] c;
        c = n;
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic [PAGE_W-1:0] pg,
                                input bit last, output bit produced, output page_result_t r);
        run_crc  = (run_crc >> 8) ^ crc_table[run_crc[7:0] ^ b];
        produced = last;
        r        = '0;
        if (last) begin
            r.page  = pg;
            r.crc   = run_crc ^ CRC_ONES;
            run_crc = CRC_ONES;
            // only the index with the last byte counts; mode is sampled here too
            if ({1'b0, pg} >= model_pages) begin
                r.status = ST_RANGE;
            end else if (model_learn) begin
                baseline[pg] = r.crc;
                learned[pg]  = 1'b1;
                r.status     = ST_STORED;
            end else begin
                r.status = (baseline[pg] == r.crc) ? ST_MATCH : ST_MISMATCH;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Idle / stall control
    // ------------------------------------------------------------------
    bit gaps_on = 1'b1;  // cleared for the final phase
    bit calm    = 1'b0;  // random quiet stretches with no idling at all
    int stall_left = 0;

    always @(posedge aclk) begin
        if ($urandom_range(0, 299) == 0) begin
            calm <= !calm;
        end
    end

    // sink stalls in bursts of random length
    always @(posedge aclk) begin
        if (gaps_on && stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (gaps_on && !calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------
    int           fail_count = 0;
    int           items_sent = 0;
    int           reg_writes = 0;
    int           status_seen [0:3] = '{0, 0, 0, 0};
    int           cycle_count = 0;
    page_result_t seen_res;
    page_result_t want_res;

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_res.page   = m_tdata[12:0];
            seen_res.crc    = m_tdata[44:13];
            seen_res.status = m_tuser;
            status_seen[seen_res.status]++;
            if (pending_results.size() == 0) begin
                note_fail($sformatf("unexpected result page=%0d crc=%08h status=%0d",
                                    seen_res.page, seen_res.crc, seen_res.status));
            end else begin
                want_res = pending_results.pop_front();
                if (seen_res.page !== want_res.page || seen_res.crc !== want_res.crc ||
                    seen_res.status !== want_res.status) begin
                    note_fail($sformatf(
                        "page/crc/status exp %0d/%08h/%0d got %0d/%08h/%0d",
                        want_res.page, want_res.crc, want_res.status,
                        seen_res.page, seen_res.crc, seen_res.status));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // One byte item; valid stays high into the next item unless a gap is taken.
    task automatic put_item(input logic [BYTE_W-1:0] b, input logic [PAGE_W-1:0] pg,
                            input bit last, input bit known,
                            input logic [CRC_W-1:0] k_crc, input logic [STAT_W-1:0] k_st);
        bit           produced;
        page_result_t r;
        if (gaps_on && !calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, pg, b};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_byte(b, pg, last, produced, r);
        if (produced) begin
            if (known) begin
                r.crc    = k_crc;
                r.status = k_st;
            end
            pending_results.push_back(r);
        end
        items_sent++;
    endtask

    // Register write, only once the block has drained.
    task automatic write_reg(input logic sel, input logic [CNT_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (sel == CFG_LEARN_MODE) begin
            model_learn = val[0];
        end else begin
            model_pages = val;
        end
        reg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Random page generation
    // ------------------------------------------------------------------
    logic [PAGE_W-1:0] pool_page  [0:POOL_N-1];
    int                pool_len   [0:POOL_N-1];
    logic [BYTE_W-1:0] pool_bytes [0:POOL_N-1][0:BUF_MAX-1];
    logic [BYTE_W-1:0] page_buf   [0:BUF_MAX-1];

    function automatic logic [PAGE_W-1:0] beyond_count(input logic [CNT_W-1:0] pages);
        if (pages < MAX_PAGES) begin
            return PAGE_W'($urandom_range(pages, MAX_PAGES - 1));
        end
        return PAGE_W'($urandom_range(0, MAX_PAGES - 1));
    endfunction

    // in check mode an in-range page must already hold a baseline
    function automatic logic [PAGE_W-1:0] legal_page(input logic [PAGE_W-1:0] pg,
                                                     input bit learn,
                                                     input logic [CNT_W-1:0] pages);
        if (learn || {1'b0, pg} >= pages || learned[pg]) begin
            return pg;
        end
        if (pages < MAX_PAGES) begin
            return beyond_count(pages);
        end
        return PAGE_W'(MAX_PAGES - 1);  // learned in the directed part
    endfunction

    task automatic send_page(input logic [PAGE_W-1:0] pg, input int len);
        logic [PAGE_W-1:0] noise;
        for (int i = 0; i < len; i++) begin
            // earlier bytes may carry a stray index; only the last one counts
            noise = ($urandom_range(0, 3) == 0) ? PAGE_W'($urandom_range(0, MAX_PAGES - 1)) : pg;
            put_item(page_buf[i], (i == len - 1) ? pg : noise, i == len - 1, 1'b0, '0, '0);
        end
    endtask

    task automatic run_phase(input bit learn, input logic [CNT_W-1:0] pages,
                             input int quota, input bit gaps);
        int                start;
        int                kind;
        int                len;
        int                p;
        logic [PAGE_W-1:0] pg;
        write_reg(CFG_LEARN_MODE, CNT_W'(learn));
        write_reg(CFG_PAGE_COUNT, pages);
        gaps_on = gaps;
        start   = items_sent;
        while (items_sent - start < quota) begin
            kind = $urandom_range(0, 9);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, BUF_MAX) : $urandom_range(1, 8);
            if (kind < 6) begin
                // well-formed learn/check traffic on the replay pool
                p  = $urandom_range(0, POOL_N - 1);
                pg = pool_page[p];
                if (learn) begin
                    pool_len[p] = len;
                    for (int i = 0; i < len; i++) pool_bytes[p][i] = 8'($urandom_range(0, 255));
                end
                len = pool_len[p];
                for (int i = 0; i < len; i++) page_buf[i] = pool_bytes[p][i];
                if (!learn && $urandom_range(0, 2) == 0) begin
                    page_buf[$urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
                end
            end else begin
                pg = (kind < 8) ? PAGE_W'($urandom_range(0, MAX_PAGES - 1))
                                : beyond_count(pages);
                for (int i = 0; i < len; i++) page_buf[i] = 8'($urandom_range(0, 255));
            end
            send_page(legal_page(pg, learn, pages), len);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    stim_row_t dir_rows [$];

    function automatic stim_row_t reg_row(input logic sel, input logic [CNT_W-1:0] val);
        stim_row_t r;
        r         = '{default: '0};
        r.is_reg  = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    function automatic stim_row_t byte_row(input logic [BYTE_W-1:0] b,
                                           input logic [PAGE_W-1:0] pg, input bit last);
        stim_row_t r;
        r      = '{default: '0};
        r.data = b;
        r.page = pg;
        r.last = last;
        return r;
    endfunction

    function automatic stim_row_t known_row(input logic [BYTE_W-1:0] b,
                                            input logic [PAGE_W-1:0] pg,
                                            input logic [CRC_W-1:0] crc,
                                            input logic [STAT_W-1:0] st);
        stim_row_t r;
        r        = byte_row(b, pg, 1'b1);
        r.known  = 1'b1;
        r.crc    = crc;
        r.status = st;
        return r;
    endfunction

    // CRC-32 of a single 0x00 byte is D202EF8D, of a single 0xFF byte FF000000
    task automatic build_table();
        // after reset page_count is zero: everything out of range
        dir_rows.push_back(known_row(8'h00, 13'd0,    32'hD202_EF8D, ST_RANGE));
        dir_rows.push_back(known_row(8'hFF, 13'd8191, 32'hFF00_0000, ST_RANGE));
        dir_rows.push_back(reg_row(CFG_PAGE_COUNT, 14'd8192));
        dir_rows.push_back(reg_row(CFG_LEARN_MODE, 14'd1));
        dir_rows.push_back(known_row(8'hFF, 13'd8191, 32'hFF00_0000, ST_STORED));
        dir_rows.push_back(known_row(8'h00, 13'd0,    32'hD202_EF8D, ST_STORED));
        // index changes within a page: page 5 is what gets learned
        dir_rows.push_back(byte_row(8'h31, 13'd100, 1'b0));
        dir_rows.push_back(byte_row(8'h32, 13'd7,   1'b0));
        dir_rows.push_back(byte_row(8'h33, 13'd5,   1'b1));
        dir_rows.push_back(reg_row(CFG_LEARN_MODE, 14'd0));
        dir_rows.push_back(known_row(8'hFF, 13'd8191, 32'hFF00_0000, ST_MATCH));
        dir_rows.push_back(byte_row(8'h01, 13'd0, 1'b1));   // mismatch on page 0
        dir_rows.push_back(byte_row(8'h31, 13'd0, 1'b0));
        dir_rows.push_back(byte_row(8'h32, 13'd0, 1'b0));
        dir_rows.push_back(byte_row(8'h33, 13'd5, 1'b1));   // match on page 5
        // mode flipped between the bytes of one page
        dir_rows.push_back(byte_row(8'h5A, 13'd3, 1'b0));
        dir_rows.push_back(reg_row(CFG_LEARN_MODE, 14'd1));
        dir_rows.push_back(byte_row(8'hA5, 13'd3, 1'b1));
        dir_rows.push_back(reg_row(CFG_PAGE_COUNT, 14'd4));
        dir_rows.push_back(byte_row(8'h77, 13'd4, 1'b1));   // first index past the count
        dir_rows.push_back(known_row(8'h00, 13'd0, 32'hD202_EF8D, ST_STORED));
        dir_rows.push_back(reg_row(CFG_LEARN_MODE, 14'd0));
        dir_rows.push_back(byte_row(8'h5A, 13'd3, 1'b0));
        dir_rows.push_back(byte_row(8'hA5, 13'd3, 1'b1));
        // page_count above the page store size
        dir_rows.push_back(reg_row(CFG_PAGE_COUNT, 14'd16383));
        dir_rows.push_back(known_row(8'hFF, 13'd8191, 32'hFF00_0000, ST_MATCH));
        dir_rows.push_back(reg_row(CFG_PAGE_COUNT, 14'd0));
        dir_rows.push_back(known_row(8'h00, 13'd0, 32'hD202_EF8D, ST_RANGE));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        for (int n = 0; n < 256; n++) crc_table[n] = crc_table_entry(n);
        for (int n = 0; n < MAX_PAGES; n++) learned[n] = 1'b0;
        for (int p = 0; p < POOL_N; p++) begin
            // half the pool below 100 so the narrow phases still see matches
            pool_page[p] = (p < POOL_N / 2) ? PAGE_W'($urandom_range(0, 99))
                                            : PAGE_W'($urandom_range(0, MAX_PAGES - 1));
            pool_len[p]  = $urandom_range(1, 8);
            for (int i = 0; i < BUF_MAX; i++) pool_bytes[p][i] = 8'($urandom_range(0, 255));
        end
        pool_page[0] = 13'd0;
        pool_page[1] = 13'd8191;
        pool_page[2] = 13'd99;
        build_table();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_reg) begin
                write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_val);
            end else begin
                put_item(dir_rows[i].data, dir_rows[i].page, dir_rows[i].last,
                         dir_rows[i].known, dir_rows[i].crc, dir_rows[i].status);
            end
        end

        // learn/check pairs over wide, oversized, narrow and one-page regions, a check over an empty one
        run_phase(1'b1, 14'd8192,  220, 1'b1);
        run_phase(1'b0, 14'd8192,  220, 1'b1);
        run_phase(1'b1, 14'd16383, 150, 1'b1);
        run_phase(1'b0, 14'd16383, 150, 1'b1);
        run_phase(1'b1, 14'd100,   150, 1'b1);
        run_phase(1'b0, 14'd100,   150, 1'b1);
        run_phase(1'b0, 14'd0,     100, 1'b1);
        run_phase(1'b1, 14'd1,      80, 1'b1);
        run_phase(1'b0, 14'd1,      80, 1'b1);
        run_phase(1'b1, 14'd8192,  100, 1'b1);
        run_phase(1'b0, 14'd8192,  150, 1'b0);  // back-to-back, no idling

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run: %0d byte items, %0d register writes, %0d mismatches logged",
                 items_sent, reg_writes, fail_count);
        $display("Results: %0d match, %0d mismatch, %0d stored, %0d out of range",
                 status_seen[ST_MATCH], status_seen[ST_MISMATCH],
                 status_seen[ST_STORED], status_seen[ST_RANGE]);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/pcrc_pkg.sv
rtl/pcrc_front.sv
rtl/pcrc_queue.sv
rtl/pcrc_back.sv
rtl/page_crc32_integrity_checker.sv
test/testbench.sv
